### hw/rtl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes of the first-fit block allocator
// Beat layouts of the request and response channels, command and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffba_pkg;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NOFIT    = 2'd1;
	localparam logic [1:0] STATUS_NOTALLOC = 2'd2;

	typedef struct packed {
		logic       command;
		logic [7:0] request_bytes;
		logic [5:0] payload_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] granted_index;
	} rsp_t;

endpackage

### hw/rtl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/first_fit_block_allocator_core.sv
// Sequence: an allocate runs the walk state, one header per step, then the split state when
// it finds a block, then the done state; a free runs the free state and then the done state,
// and a free at index zero or outside the store goes straight to the done state.
// Throughput: one request at a time; the header walk reads one word of the store per cycle.
// Reset: asynchronous, active low; the store needs no clearing pass because word 0 has a
// reset flag of its own and reads as one free block covering the store until first written.
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core: first-fit allocator over an implicit free list
// Block headers live in a word store. An allocate walks the headers from word 0
// and takes the first free block that is large enough, splitting off the rest;
// a free clears the allocated bit of the header in front of the payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_block_allocator_core #(
	parameter int CAPACITY_WORDS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ffba_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ffba_pkg::rsp_t rsp
);

	// Store address width, header width (size in bytes plus the allocated bit),
	// walk index width (room for index plus step), and size compare width.
	localparam int AW    = (CAPACITY_WORDS > 1) ? $clog2(CAPACITY_WORDS) : 1;
	localparam int HDR_W = $clog2(CAPACITY_WORDS * 4) + 1;
	localparam int IW    = (AW + 2 > 9) ? AW + 2 : 9;
	localparam int CW    = ((HDR_W > 9) ? HDR_W : 9) + 1;

	localparam logic [HDR_W-1:0] RESET_HDR = HDR_W'(CAPACITY_WORDS * 4);
	localparam logic [IW-1:0]    CAP_IDX   = IW'(CAPACITY_WORDS);

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_WALK  = 3'd1;
	localparam logic [2:0] S_SPLIT = 3'd2;
	localparam logic [2:0] S_FREE  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [IW-1:0]    idx_q;
	logic [CW-1:0]    need_q;
	logic [HDR_W-1:0] rem_q;
	logic [AW-1:0]    rem_at_q;
	logic             split_q;
	logic [AW-1:0]    free_addr_q;
	logic [1:0]       status_q;
	logic [5:0]       grant_q;
	logic             w0_written_q;
	logic             rd_zero_q;
	logic             rsp_valid_q;
	ffba_pkg::rsp_t   rsp_q;

	logic             accept;
	logic             rsp_load;
	logic [CW-1:0]    need_c;
	logic [HDR_W-1:0] rdata;
	logic [HDR_W-1:0] hdr;
	logic [CW-1:0]    size_c;
	logic [IW-1:0]    step_c;
	logic [IW-1:0]    next_c;
	logic [IW-1:0]    idx_inc_c;
	logic [IW-1:0]    rem_at_c;
	logic             fits_c;
	logic [IW-1:0]    pidx_c;
	logic [IW-1:0]    pidx_m1_c;
	logic             free_bad_c;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [HDR_W-1:0] wdata;
	logic [AW-1:0]    raddr;

	// The block takes a request beat only while the sequencer is idle; a finished
	// response waits in its own register, so a new request may start meanwhile.
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The response register is loaded from the done state whenever it is empty
	// or its current beat is being taken in this cycle.
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Block size needed: payload rounded up to whole words, plus the header word.
	assign need_c = ((CW'(req.request_bytes) + CW'(3)) & ~CW'(3)) + CW'(4);

	// Word 0 reads as the initial whole-store free block until it is first written.
	assign hdr = (rd_zero_q && !w0_written_q) ? RESET_HDR : rdata;

	// Shared walk datapath: one header is judged per cycle.
	assign size_c    = CW'({hdr[HDR_W-1:1], 1'b0});
	assign step_c    = IW'(hdr[HDR_W-1:2]);
	assign next_c    = idx_q + step_c;
	assign idx_inc_c = idx_q + IW'(1);
	assign rem_at_c  = idx_q + IW'(need_q >> 2);
	// A block whose payload would start past the last word is skipped.
	assign fits_c    = !hdr[0] && (size_c >= need_q) && (idx_inc_c < CAP_IDX);

	assign pidx_c     = IW'(req.payload_index);
	assign pidx_m1_c  = pidx_c - IW'(1);
	assign free_bad_c = (pidx_c == '0) || (pidx_c >= CAP_IDX);

	// Store port control. The read issued in one cycle is judged in the next, so
	// the walk computes the next header address straight from the current header.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && req.command == ffba_pkg::CMD_FREE) begin
					raddr = pidx_m1_c[AW-1:0];
				end
			end
			S_WALK: begin
				if (fits_c) begin
					we    = 1'b1;
					waddr = idx_q[AW-1:0];
					wdata = HDR_W'(need_q) | HDR_W'(1);
				end else begin
					raddr = next_c[AW-1:0];
				end
			end
			S_SPLIT: begin
				we    = split_q;
				waddr = rem_at_q;
				wdata = rem_q;
			end
			S_FREE: begin
				we    = hdr[0];
				waddr = free_addr_q;
				wdata = {hdr[HDR_W-1:1], 1'b0};
			end
			default: begin
			end
		endcase
	end

	ffba_ram #(
		.WIDTH(HDR_W),
		.DEPTH(CAPACITY_WORDS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			w0_written_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (we && waddr == '0) begin
				w0_written_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.command == ffba_pkg::CMD_ALLOC) begin
							state_q <= S_WALK;
						end else if (free_bad_c) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_FREE;
						end
					end
				end
				S_WALK: begin
					if (fits_c) begin
						state_q <= S_SPLIT;
					end else if (step_c == '0 || next_c >= CAP_IDX) begin
						state_q <= S_DONE;
					end
				end
				S_SPLIT: state_q <= S_DONE;
				S_FREE:  state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer and the response beat.
	always_ff @(posedge clk) begin
		rd_zero_q <= (raddr == '0);
		if (rsp_load) begin
			rsp_q.status        <= status_q;
			rsp_q.granted_index <= grant_q;
		end
		case (state_q)
			S_IDLE: begin
				idx_q       <= '0;
				need_q      <= need_c;
				free_addr_q <= pidx_m1_c[AW-1:0];
				status_q    <= ffba_pkg::STATUS_NOTALLOC;
				grant_q     <= '0;
			end
			S_WALK: begin
				if (fits_c) begin
					status_q <= ffba_pkg::STATUS_OK;
					grant_q  <= idx_inc_c[5:0];
					split_q  <= (size_c > need_q) && (rem_at_c < CAP_IDX);
					rem_q    <= HDR_W'(size_c - need_q);
					rem_at_q <= rem_at_c[AW-1:0];
				end else if (step_c == '0 || next_c >= CAP_IDX) begin
					status_q <= ffba_pkg::STATUS_NOFIT;
					grant_q  <= '0;
				end else begin
					idx_q <= next_c;
				end
			end
			S_FREE: begin
				status_q <= hdr[0] ? ffba_pkg::STATUS_OK : ffba_pkg::STATUS_NOTALLOC;
				grant_q  <= '0;
			end
			default: begin
			end
		endcase
	end

endmodule

### hw/rtl/ffba_chk.sv
// ----------------------------------------------------------------------------
// ffba_chk: port checker for the first-fit block allocator
// Watches the request and response channels and flags illegal behavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffba_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input ffba_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input ffba_pkg::rsp_t rsp
);

	// A response beat held under stall does not change.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed while stalled");

	// Only the three defined status codes ever leave the block.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ffba_pkg::STATUS_OK ||
			rsp.status == ffba_pkg::STATUS_NOFIT ||
			rsp.status == ffba_pkg::STATUS_NOTALLOC))
		else $error("undefined status code");

	// A failed request never grants an index.
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ffba_pkg::STATUS_OK |-> rsp.granted_index == '0)
		else $error("failed request carries a granted index");

	// Once a request is taken the block is busy with it in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while the first is in progress");

endmodule

bind first_fit_block_allocator_core ffba_chk u_ffba_chk (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the first-fit block allocator
// A directed sequence covers the corner cases: exact fit, no fit, a block at
// the store end, frees at index zero, double frees and oversized requests.
// Random traffic then follows, mostly allocates and frees of live blocks. Both
// channels idle and stall at random. A predictor of the header store in the bench
// works out every response beat, and a monitor compares each accepted one to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int CAPACITY_WORDS = 64;
	// Cycles without any accepted beat before the run is declared hung. The
	// slowest legal case is a long sender gap, a full 64-header walk and a long
	// receiver stall, so this leaves a wide margin.
	localparam int HANG_LIMIT     = 2000;
	// Settle time after the last response, a little above the longest walk.
	localparam int DRAIN_CYCLES   = 80;
	localparam int RANDOM_ITEMS   = 1100;
	localparam int BURST_ITEMS    = 250;
	// The sender stops and waits for the pipeline to empty this often.
	localparam int PAUSE_EVERY    = 200;
	localparam int REPORT_LIMIT   = 10;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	ffba_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	ffba_pkg::rsp_t rsp;

	first_fit_block_allocator_core #(
		.CAPACITY_WORDS(CAPACITY_WORDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow copy of the header store. A word counts as written once the
	// allocator could have stored a header there. Stimulus never frees a
	// payload whose header word was never written.
	logic [8:0] header_word [CAPACITY_WORDS];
	bit         header_written [CAPACITY_WORDS];

	// Responses still owed by the block, oldest first.
	ffba_pkg::rsp_t owed_rsp [$];
	// Payload indexes currently allocated, so random frees can hit live blocks.
	int         live_payloads [$];

	int         mismatch_count = 0;
	int         responses_seen = 0;
	int         requests_sent  = 0;
	int         grants         = 0;
	int         releases       = 0;
	int         no_fits        = 0;
	int         refused_frees  = 0;
	int         quiet_cycles   = 0;
	int         stall_left     = 0;
	bit         idling_on      = 1'b1;
	ffba_pkg::rsp_t oldest_owed;

	// Gap length for either side: mostly none, often a few cycles, rarely long.
	// With idling switched off, both sides run at full speed.
	function automatic int pick_gap();
		int roll;
		if (!idling_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Computes the response to one request and applies it to the shadow store.
	// An allocate walks the headers from word 0. The first free block that is
	// big enough wins. A split writes a remainder header unless the fit is exact.
	// A free block in the last word cannot hold a payload, so the walk skips it.
	function automatic ffba_pkg::rsp_t predict_rsp(ffba_pkg::req_t r);
		ffba_pkg::rsp_t res;
		int   need;
		int   at;
		int   word;
		int   size;
		int   step;
		int   p;
		bit   walking;
		res.status        = ffba_pkg::STATUS_OK;
		res.granted_index = '0;
		if (r.command == ffba_pkg::CMD_ALLOC) begin
			need    = ((int'(r.request_bytes) + 3) & ~3) + 4;
			res.status = ffba_pkg::STATUS_NOFIT;
			at      = 0;
			walking = 1'b1;
			while (walking && at < CAPACITY_WORDS) begin
				word = header_written[at] ? int'(header_word[at]) : 0;
				size = word & ~1;
				step = word >> 2;
				if ((word & 1) == 0 && size >= need && at + 1 < CAPACITY_WORDS) begin
					header_word[at]    = 9'(need + 1);
					header_written[at] = 1'b1;
					if (size > need && at + need / 4 < CAPACITY_WORDS) begin
						header_word[at + need / 4]    = 9'(size - need);
						header_written[at + need / 4] = 1'b1;
					end
					res.status        = ffba_pkg::STATUS_OK;
					res.granted_index = 6'(at + 1);
					walking           = 1'b0;
				end else if (step == 0) begin
					// A zero-sized header would stall the walk; it ends as no fit.
					walking = 1'b0;
				end else begin
					at += step;
				end
			end
		end else begin
			p = int'(r.payload_index);
			if (p == 0 || p >= CAPACITY_WORDS || !header_written[p - 1] ||
			    header_word[p - 1][0] == 1'b0)
				res.status = ffba_pkg::STATUS_NOTALLOC;
			else
				header_word[p - 1] = header_word[p - 1] - 9'd1;
		end
		return res;
	endfunction

	// Builds a request. The field that the command ignores gets random bits,
	// so every bit of both fields toggles over the run.
	function automatic ffba_pkg::req_t make_req(logic cmd, int bytes, int index);
		ffba_pkg::req_t r;
		r.command       = cmd;
		r.request_bytes = (cmd == ffba_pkg::CMD_ALLOC) ? 8'(bytes) : 8'($urandom);
		r.payload_index = (cmd == ffba_pkg::CMD_FREE) ? 6'(index) : 6'($urandom);
		return r;
	endfunction

	// Sends one request beat after a random gap. When the beat is accepted,
	// the expected response is queued and the live-block list is updated.
	// Valid stays high on return, so the next call can follow back to back.
	task automatic send_request(input ffba_pkg::req_t r);
		int   gap;
		int   hit;
		ffba_pkg::rsp_t predicted;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = predict_rsp(r);
		owed_rsp.push_back(predicted);
		requests_sent++;
		if (r.command == ffba_pkg::CMD_ALLOC) begin
			if (predicted.status == ffba_pkg::STATUS_OK) begin
				grants++;
				live_payloads.push_back(int'(predicted.granted_index));
			end else begin
				no_fits++;
			end
		end else if (predicted.status == ffba_pkg::STATUS_OK) begin
			releases++;
			hit = -1;
			for (int k = 0; k < live_payloads.size(); k++)
				if (live_payloads[k] == int'(r.payload_index))
					hit = k;
			if (hit >= 0)
				live_payloads.delete(hit);
		end else begin
			refused_frees++;
		end
	endtask

	// Drops valid and waits until the block has answered everything sent.
	task automatic drain_requests();
		@(negedge clk);
		req_valid <= 1'b0;
		while (owed_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Walks the allocator through its corner cases from the reset state.
	task automatic test_directed_cases();
		send_request(make_req(ffba_pkg::CMD_ALLOC, 252, 0));  // exact fit of the whole store
		send_request(make_req(ffba_pkg::CMD_ALLOC, 0, 0));    // store is full
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 0));     // free at index zero
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 1));
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 1));     // double free
		send_request(make_req(ffba_pkg::CMD_ALLOC, 255, 0));  // larger than the store
		send_request(make_req(ffba_pkg::CMD_ALLOC, 253, 0));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 248, 0));  // leaves a one-word block
		send_request(make_req(ffba_pkg::CMD_ALLOC, 0, 0));    // that block holds no payload
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 1));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 0, 0));    // splits the freed block
		send_request(make_req(ffba_pkg::CMD_ALLOC, 3, 0));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 1, 0));
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 2));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 4, 0));    // refills the freed hole exactly
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 4));
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 2));
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 1));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 252, 0));  // fragmented: walks every block
		send_request(make_req(ffba_pkg::CMD_ALLOC, 224, 0));  // remainder header in word 62
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 63));    // that block is free
		send_request(make_req(ffba_pkg::CMD_ALLOC, 0, 0));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 4, 0));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 4, 0));
		send_request(make_req(ffba_pkg::CMD_ALLOC, 0, 0));    // payload at the highest index
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 63));
		send_request(make_req(ffba_pkg::CMD_FREE, 0, 6));
	endtask

	// Random traffic: mostly allocate requests and frees of live blocks, plus
	// frees aimed at arbitrary headers and at index zero. Sizes are mostly
	// small so the fragmented store keeps granting.
	task automatic test_random_traffic(input int count);
		ffba_pkg::req_t r;
		int   roll;
		int   w;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 42 && live_payloads.size() > 0) begin
				r = make_req(ffba_pkg::CMD_FREE, 0,
				             live_payloads[$urandom_range(0, live_payloads.size() - 1)]);
			end else if (roll < 55) begin
				// Either a header that exists (a live block or a double free) or zero.
				w = $urandom_range(0, CAPACITY_WORDS - 2);
				for (int t = 0; t < 8 && !header_written[w]; t++)
					w = $urandom_range(0, CAPACITY_WORDS - 2);
				if (header_written[w] && $urandom_range(0, 9) != 0)
					r = make_req(ffba_pkg::CMD_FREE, 0, w + 1);
				else
					r = make_req(ffba_pkg::CMD_FREE, 0, 0);
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					r = make_req(ffba_pkg::CMD_ALLOC, $urandom_range(0, 24), 0);
				else if (roll < 95)
					r = make_req(ffba_pkg::CMD_ALLOC, $urandom_range(0, 252), 0);
				else
					r = make_req(ffba_pkg::CMD_ALLOC, $urandom_range(253, 255), 0);
			end
			send_request(r);
			if (n % PAUSE_EVERY == PAUSE_EVERY - 1)
				drain_requests();
		end
	endtask

	// The same traffic with both sides running flat out.
	task automatic test_back_to_back(input int count);
		idling_on = 1'b0;
		test_random_traffic(count);
		idling_on = 1'b1;
	endtask

	// Receiver: random stall stretches, changed only at the falling edge.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	// Response monitor: every accepted beat must match the oldest owed response.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			responses_seen++;
			if (owed_rsp.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("%0t: unexpected response status=%0d index=%0d", $realtime,
					         rsp.status, rsp.granted_index);
				mismatch_count++;
			end else begin
				oldest_owed = owed_rsp.pop_front();
				if (rsp.status !== oldest_owed.status ||
				    rsp.granted_index !== oldest_owed.granted_index) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: expected status=%0d index=%0d, got status=%0d index=%0d",
						         $realtime, oldest_owed.status, oldest_owed.granted_index,
						         rsp.status, rsp.granted_index);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: ends the run once no beat has moved on either side for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles, %0d responses outstanding",
			         $realtime, HANG_LIMIT, owed_rsp.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		// After reset, word 0 is one free block that covers the whole store.
		for (int k = 0; k < CAPACITY_WORDS; k++) begin
			header_word[k]    = '0;
			header_written[k] = 1'b0;
		end
		header_word[0]    = 9'(CAPACITY_WORDS * 4);
		header_written[0] = 1'b1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		// The sender holds off here until every response has come back.
		drain_requests();
		test_random_traffic(RANDOM_ITEMS);
		test_back_to_back(BURST_ITEMS);

		drain_requests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (owed_rsp.size() != 0) begin
			$display("%0d responses never arrived", owed_rsp.size());
			mismatch_count += owed_rsp.size();
		end

		$display("Run covered %0d requests: %0d grants, %0d frees, %0d no-fit, %0d refused.",
		         requests_sent, grants, releases, no_fits, refused_frees);
		$display("Checked %0d responses, %0d mismatches.", responses_seen, mismatch_count);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
